>>> sv/delimiter_frame_splitter_assert.svh
// Assertion macros for the delimiter frame splitter.
`ifndef DELIMITER_FRAME_SPLITTER_ASSERT_SVH
`define DELIMITER_FRAME_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define DFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/dfs_pkg.sv
// Shared types and constants for the delimiter frame splitter.
package dfs_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_W      = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_PATTERN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME_LEN = 1'b1;

   localparam logic [CSR_DATA_W-1:0] PATTERN_RESET = 64'hF708_FB04_FD02_FE01;
   localparam logic [LEN_W-1:0]      MAXLEN_RESET  = 16'd1500;
   localparam logic [LEN_W-1:0]      COUNT_MAX     = 16'hFFFF;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       overlong;
      logic       aborted;
   } rsp_type;

   typedef struct packed {
      logic pending_valid;
      logic window_empty;
   } core_status_type;

endpackage

>>> sv/dfs_core.sv
// Delimiter match window, pending byte and frame counter.
module dfs_core import dfs_pkg::*; #(
   parameter int DELIM_LEN = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  req_type                in_data,
   input  logic [8*DELIM_LEN-1:0] pattern,
   input  logic [LEN_W-1:0]       max_len,
   output logic                   res_valid,
   output rsp_type                res_data,
   output core_status_type        status
);

   localparam int PAT_W  = 8 * DELIM_LEN;
   localparam int FILL_W = $clog2(DELIM_LEN);

   logic [PAT_W-1:0]  window_ff, window_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        pending_ff, pending_in;
   logic              pending_valid_ff, pending_valid_in;
   logic [LEN_W-1:0]  count_ff, count_in;

   logic [PAT_W-1:0]  win_ins;
   logic              full;
   logic              match;
   logic              overlong;

   // Drop the new byte into the first free lane.
   always_comb begin
      win_ins = window_ff;
      for (int i = 0; i < DELIM_LEN; i++) begin
         if (fill_ff == FILL_W'(i)) begin
            win_ins[8*i +: 8] = in_data.in_byte;
         end
      end
   end

   assign full     = (fill_ff == FILL_W'(DELIM_LEN - 1));
   assign match    = (win_ins == pattern);
   assign overlong = (count_ff > max_len);

   always_comb begin
      window_in        = window_ff;
      fill_in          = fill_ff;
      pending_in       = pending_ff;
      pending_valid_in = pending_valid_ff;
      count_in         = count_ff;
      res_valid        = 1'b0;
      res_data         = '0;
      if (in_valid) begin
         if (in_data.kind == KIND_RESTART) begin
            // abort an open frame, drop everything
            res_valid        = pending_valid_ff;
            res_data.aborted = 1'b1;
            window_in        = '0;
            fill_in          = '0;
            pending_valid_in = 1'b0;
            count_in         = '0;
         end else if (!full) begin
            window_in = win_ins;
            fill_in   = fill_ff + FILL_W'(1);
         end else if (match) begin
            // delimiter closes the frame on the pending byte
            res_valid         = pending_valid_ff;
            res_data.out_byte = pending_ff;
            res_data.last     = 1'b1;
            res_data.overlong = overlong;
            window_in         = '0;
            fill_in           = '0;
            pending_valid_in  = 1'b0;
            count_in          = '0;
         end else begin
            // oldest window byte is confirmed as data
            res_valid         = pending_valid_ff;
            res_data.out_byte = pending_ff;
            res_data.overlong = overlong;
            pending_in        = win_ins[7:0];
            pending_valid_in  = 1'b1;
            window_in         = {8'h00, win_ins[PAT_W-1:8]};
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff        <= '0;
         fill_ff          <= '0;
         pending_ff       <= '0;
         pending_valid_ff <= 1'b0;
         count_ff         <= '0;
      end else begin
         window_ff        <= window_in;
         fill_ff          <= fill_in;
         pending_ff       <= pending_in;
         pending_valid_ff <= pending_valid_in;
         count_ff         <= count_in;
      end
   end

   assign status.pending_valid = pending_valid_ff;
   assign status.window_empty  = (fill_ff == '0);

endmodule

>>> sv/dfs_out_buf.sv
// Result register with a skid stage.
module dfs_out_buf import dfs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    full,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    drain;

   assign drain = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (drain) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || drain) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            // hold the new result beside the stalled one
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (drain) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

>>> sv/delimiter_frame_splitter.sv
// Results reach rsp through the result register, via the skid stage if stalled.
// A data byte is emitted with the data transfer after the one that confirms it.
// Throughput: one req transfer per cycle while req_stall is low.
// req_stall rises only when both result register and skid stage are full.
// Reset: synchronous; clears stream state, restores pattern and max length.
module delimiter_frame_splitter import dfs_pkg::*; #(
   parameter int DELIM_LEN = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "delimiter_frame_splitter_assert.svh"

   localparam int PAT_W = 8 * DELIM_LEN;

   logic [CSR_DATA_W-1:0] pattern_ff;
   logic [LEN_W-1:0]      max_len_ff;
   logic                  req_xfer;
   logic                  res_valid;
   rsp_type               res_data;
   core_status_type       core_status;
   logic                  restart_xfer;
   logic                  stream_idle;
   logic                  abort_out;
   logic                  abort_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PATTERN_RESET;
         max_len_ff <= MAXLEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DELIM_PATTERN: pattern_ff <= csr_wdata;
            CSR_MAX_FRAME_LEN: max_len_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_xfer = req_valid && !req_stall;

   dfs_core #(
      .DELIM_LEN (DELIM_LEN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_xfer),
      .in_data   (req_data),
      .pattern   (pattern_ff[PAT_W-1:0]),
      .max_len   (max_len_ff),
      .res_valid (res_valid),
      .res_data  (res_data),
      .status    (core_status)
   );

   dfs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   assign restart_xfer = req_xfer && req_data.kind == KIND_RESTART;
   assign stream_idle  = !core_status.pending_valid && core_status.window_empty;
   assign abort_out    = rsp_valid && rsp_data.aborted;
   assign abort_empty  = rsp_data.out_byte == 8'h00 && !rsp_data.last && !rsp_data.overlong;

   `DFS_ASSERT_NOW(a_skid_behind_main, clock, reset, req_stall, rsp_valid, "skid without result")
   `DFS_ASSERT_NOW(a_abort_clean, clock, reset, abort_out, abort_empty, "abort carries data")
   `DFS_ASSERT_NEXT(a_restart_clears, clock, reset, restart_xfer, stream_idle, "state kept")
   `DFS_ASSERT_NOW(a_stall_cause, clock, reset, $rose(req_stall), $past(rsp_stall), "stray stall")

endmodule
